// File: design/pidl_pkg.sv
// ----------------------------------------------------------------------------
// Positional list package
// Sizes, operation and status codes, and the command that is broadcast
// along the row of list cells.
// ----------------------------------------------------------------------------
package pidl_pkg;

    localparam int DEPTH  = 64;
    localparam int WORD_W = 32;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int POS_W  = CNT_W;
    localparam int OP_W   = 2;
    localparam int ST_W   = 2;

    localparam logic [OP_W-1:0] OP_INSERT    = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE_LAST = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE_AT = 2'd2;
    localparam logic [OP_W-1:0] OP_READ      = 2'd3;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd3;

    // Command seen by every cell in the same cycle.
    typedef struct packed {
        logic              insert;
        logic              remove;
        logic              read;
        logic [POS_W-1:0]  pos;
        logic [WORD_W-1:0] value;
    } pidl_cmd_t;

endpackage

// File: design/pidl_cell.sv
// ----------------------------------------------------------------------------
// Positional list cell
// Holds one list entry and moves it toward its upper or lower neighbor.
// ----------------------------------------------------------------------------
module pidl_cell (
    input  logic                      clk,
    input  pidl_pkg::pidl_cmd_t       cmd,
    input  logic [pidl_pkg::POS_W-1:0]  cell_pos,
    input  logic [pidl_pkg::WORD_W-1:0] lower_word,
    input  logic [pidl_pkg::WORD_W-1:0] upper_word,
    output logic [pidl_pkg::WORD_W-1:0] word,
    output logic [pidl_pkg::WORD_W-1:0] read_word
);
    import pidl_pkg::*;

    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] word_next;

    // Insert: the target cell takes the new value and every cell above it
    // takes its lower neighbor. Removal: the target and every cell above it
    // take their upper neighbor.
    always_comb
    begin
        word_next = word_reg;
        if (cmd.insert)
        begin
            if (cell_pos == cmd.pos)
            begin
                word_next = cmd.value;
            end
            else if (cell_pos > cmd.pos)
            begin
                word_next = lower_word;
            end
        end
        else if (cmd.remove && (cell_pos >= cmd.pos))
        begin
            word_next = upper_word;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word      = word_reg;
    assign read_word = (cmd.read && (cell_pos == cmd.pos)) ? word_reg : '0;

endmodule

// File: design/positional_insert_delete_list.sv
// ----------------------------------------------------------------------------
// Positional insert/delete list
// An ordered list of up to 64 words of 32 bits, held in a row of 64 cells.
// Every transfer in on the input channel gives exactly one transfer out,
// carrying a status (ok, list empty, list full, position out of range) and
// the entry count after the operation. Positions are 1-based. Insert takes
// positions 1 to count+1 and pushes later entries up; remove-at takes
// positions 1 to count and pulls later entries down; remove-last drops the
// final entry; read returns the entry at a position, and read_value is zero
// for anything other than a successful read. A rejected operation leaves the
// list unchanged. All cells shift in parallel in the cycle the input
// transfer happens, and the result is held in an output register. A new
// item is taken in every cycle as long as the output side takes its
// results; the input stalls only while a result waits in the output
// register. After reset the list is empty and no clearing pass is needed,
// since only entries below the count are ever read.
// ----------------------------------------------------------------------------
module positional_insert_delete_list (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [pidl_pkg::OP_W-1:0]   opcode,
    input  logic [pidl_pkg::POS_W-1:0]  position,
    input  logic [pidl_pkg::WORD_W-1:0] value,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [pidl_pkg::ST_W-1:0]   status,
    output logic [pidl_pkg::CNT_W-1:0]  entry_count,
    output logic [pidl_pkg::WORD_W-1:0] read_value
);
    import pidl_pkg::*;

    // Control state.
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    // Result payload.
    logic [ST_W-1:0]   status_reg;
    logic [ST_W-1:0]   status_next;
    logic [WORD_W-1:0] read_value_reg;

    logic              accept;
    logic              is_empty;
    logic              is_full;
    logic              pos_in_list;
    logic              pos_insertable;
    pidl_cmd_t         cmd;

    logic [WORD_W-1:0] cell_word [DEPTH];
    logic [WORD_W-1:0] cell_read [DEPTH];
    logic [WORD_W-1:0] read_or;

    // The output register frees itself in the same cycle it is taken.
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign is_empty       = (count_reg == '0);
    assign is_full        = (count_reg >= CNT_W'(DEPTH));
    assign pos_in_list    = (position != '0) && ({1'b0, position} <= {1'b0, count_reg});
    assign pos_insertable = (position != '0)
                            && ({1'b0, position} <= ({1'b0, count_reg} + (CNT_W+1)'(1)));

    // Decode the item into a status, the new count and the cell command.
    always_comb
    begin
        status_next = ST_OK;
        count_next  = count_reg;
        cmd.insert  = 1'b0;
        cmd.remove  = 1'b0;
        cmd.read    = 1'b0;
        cmd.pos     = position;
        cmd.value   = value;
        case (opcode)
            OP_INSERT:
            begin
                if (is_full)
                begin
                    status_next = ST_FULL;
                end
                else if (!pos_insertable)
                begin
                    status_next = ST_RANGE;
                end
                else
                begin
                    cmd.insert = accept;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_REMOVE_LAST:
            begin
                if (is_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            OP_REMOVE_AT:
            begin
                if (is_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else if (!pos_in_list)
                begin
                    status_next = ST_RANGE;
                end
                else
                begin
                    cmd.remove = accept;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            OP_READ:
            begin
                if (is_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else if (!pos_in_list)
                begin
                    status_next = ST_RANGE;
                end
                else
                begin
                    cmd.read = 1'b1;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    // The row of cells. The bottom cell sees zero below it and the top cell
    // sees zero above it; neither value can reach a live entry.
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic [WORD_W-1:0] lower_w;
            logic [WORD_W-1:0] upper_w;
            if (gi == 0)
            begin : g_bottom
                assign lower_w = '0;
            end
            else
            begin : g_mid_lo
                assign lower_w = cell_word[gi-1];
            end
            if (gi == DEPTH - 1)
            begin : g_top
                assign upper_w = '0;
            end
            else
            begin : g_mid_hi
                assign upper_w = cell_word[gi+1];
            end
            pidl_cell u_cell (
                .clk        (clk),
                .cmd        (cmd),
                .cell_pos   (POS_W'(gi + 1)),
                .lower_word (lower_w),
                .upper_word (upper_w),
                .word       (cell_word[gi]),
                .read_word  (cell_read[gi])
            );
        end
    endgenerate

    // At most one cell drives a nonzero read word, so an OR collects it.
    always_comb
    begin
        read_or = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            read_or = read_or | cell_read[i];
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg     <= status_next;
            read_value_reg <= read_or;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign entry_count = count_reg;
    assign read_value  = read_value_reg;

    // The count never runs past the list size.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above list size");

    // A full report only comes with a full list, an empty report with none.
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg == ST_FULL)) |-> (count_reg == CNT_W'(DEPTH)))
        else $error("full status without a full list");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg == ST_EMPTY)) |-> (count_reg == '0))
        else $error("empty status with entries present");

    // A rejected item leaves the count where it was.
    a_reject_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (status_next != ST_OK)) |=> (count_reg == $past(count_reg)))
        else $error("rejected item changed the count");

    // Only a successful read carries data.
    a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg != ST_OK)) |-> (read_value_reg == '0))
        else $error("read data on a failed item");

endmodule
